FILE: rtl/projective_point_transform_2d_core_defines.svh
// Assertion macros used by projective_point_transform_2d_core.sv.
`ifndef PROJECTIVE_POINT_TRANSFORM_2D_CORE_DEFINES_SVH
`define PROJECTIVE_POINT_TRANSFORM_2D_CORE_DEFINES_SVH

// Same-cycle implication.
`define PPT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define PPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// Types, widths and helpers of the projective 2D point transform.
// ----------------------------------------------------------------------------
package ppt_pkg;

   localparam int CoefW  = 16;
   localparam int PointW = 32;
   localparam int RowW   = 48;
   localparam int ProdW  = PointW + CoefW;
   localparam int SumW   = 50;
   localparam int MagW   = 49;
   localparam int RemW   = MagW + 1;
   localparam int QuoW   = 32;
   localparam int FracW  = 16;

   localparam logic [RowW-1:0] Row0Reset = 48'h0000_0000_0100;
   localparam logic [RowW-1:0] Row1Reset = 48'h0000_0100_0000;
   localparam logic [RowW-1:0] Row2Reset = 48'h0100_0000_0000;

   typedef enum logic [1:0] {
      CSR_ROW0 = 2'd0,
      CSR_ROW1 = 2'd1,
      CSR_ROW2 = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [PointW-1:0] in_x;
      logic signed [PointW-1:0] in_y;
   } req_type;

   typedef struct packed {
      logic signed [PointW-1:0] out_x;
      logic signed [PointW-1:0] out_y;
      logic                     w_zero;
      logic                     saturated;
   } rsp_type;

   // one quotient lane of the divider chain
   typedef struct packed {
      logic [RemW-1:0] rem;
      logic [QuoW-1:0] low;
      logic [QuoW-1:0] quo;
      logic            neg;
      logic            ovf;
   } lane_type;

   typedef struct packed {
      lane_type        lx;
      lane_type        ly;
      logic [MagW-1:0] den;
      logic            w_zero;
   } div_type;

   function automatic logic signed [CoefW-1:0] coef(input logic [RowW-1:0] row,
                                                    input logic [1:0] col);
      logic signed [CoefW-1:0] c;
      c = row[col*CoefW +: CoefW];
      return c;
   endfunction

endpackage

FILE: rtl/ppt_mac.sv
// ----------------------------------------------------------------------------
// ppt_mac
// Multiplies (x, y, 1) by the matrix and prepares divider operands.
// ----------------------------------------------------------------------------
module ppt_mac (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  ppt_pkg::req_type            req,
   input  logic [ppt_pkg::RowW-1:0]    row0,
   input  logic [ppt_pkg::RowW-1:0]    row1,
   input  logic [ppt_pkg::RowW-1:0]    row2,
   output logic                        out_valid,
   output ppt_pkg::div_type            div
);
   import ppt_pkg::*;

   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [ProdW-1:0]  prod_ff [6];
   logic signed [CoefW-1:0]  trans_ff [3];
   logic signed [SumW-1:0]   sum_ff [3];
   logic signed [SumW-1:0]   sum_in [3];
   div_type                  div_ff, div_in;
   logic [MagW-1:0]          mag [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum_in[c] = SumW'(prod_ff[2*c]) + SumW'(prod_ff[2*c+1])
                   + (SumW'(trans_ff[c]) <<< FracW);
         mag[c] = sum_ff[c][SumW-1] ? MagW'(-sum_ff[c]) : MagW'(sum_ff[c]);
      end
      div_in.den    = mag[2];
      div_in.w_zero = (sum_ff[2] == '0);
      div_in.lx.rem = RemW'(mag[0][MagW-1:FracW]);
      div_in.lx.low = {mag[0][FracW-1:0], {FracW{1'b0}}};
      div_in.lx.quo = '0;
      div_in.lx.neg = sum_ff[0][SumW-1] ^ sum_ff[2][SumW-1];
      div_in.lx.ovf = {mag[0], {FracW{1'b0}}} >= {mag[2], {QuoW{1'b0}}};
      div_in.ly.rem = RemW'(mag[1][MagW-1:FracW]);
      div_in.ly.low = {mag[1][FracW-1:0], {FracW{1'b0}}};
      div_in.ly.quo = '0;
      div_in.ly.neg = sum_ff[1][SumW-1] ^ sum_ff[2][SumW-1];
      div_in.ly.ovf = {mag[1], {FracW{1'b0}}} >= {mag[2], {QuoW{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      for (int c = 0; c < 3; c++) begin
         prod_ff[2*c]   <= ProdW'(req.in_x) * ProdW'(coef(row0, 2'(c)));
         prod_ff[2*c+1] <= ProdW'(req.in_y) * ProdW'(coef(row1, 2'(c)));
         trans_ff[c]    <= coef(row2, 2'(c));
         sum_ff[c]      <= sum_in[c];
      end
      div_ff <= div_in;
   end

   assign out_valid = v3_ff;
   assign div       = div_ff;

endmodule

FILE: rtl/ppt_div_cell.sv
// ----------------------------------------------------------------------------
// ppt_div_cell
// One restoring-division step for both lanes; passes the beat on.
// ----------------------------------------------------------------------------
module ppt_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ppt_pkg::div_type  in_div,
   output logic              out_valid,
   output ppt_pkg::div_type  out_div
);
   import ppt_pkg::*;

   logic    valid_ff;
   div_type div_ff, div_in;

   function automatic lane_type step(input lane_type l, input logic [MagW-1:0] d);
      lane_type        o;
      logic [RemW-1:0] r;
      logic            take;
      r     = {l.rem[RemW-2:0], l.low[QuoW-1]};
      take  = r >= RemW'(d);
      o     = l;
      o.rem = take ? r - RemW'(d) : r;
      o.low = {l.low[QuoW-2:0], 1'b0};
      o.quo = {l.quo[QuoW-2:0], take};
      return o;
   endfunction

   always_comb begin
      div_in    = in_div;
      div_in.lx = step(in_div.lx, in_div.den);
      div_in.ly = step(in_div.ly, in_div.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      div_ff <= div_in;
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;

endmodule

FILE: rtl/projective_point_transform_2d_core.sv
// Pipeline: start passes 3 multiply/sum/prepare stages, 32 divider cells and
// 1 output register on its way to rsp_valid.
// Throughput: one point per cycle; busy stays low. The chain of 32 division
// cells, one quotient bit each, sets the latency.
// Reset: synchronous; clears all valid bits and loads the identity matrix.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// projective_point_transform_2d_core
// Homogeneous 2D point transform by a 3x3 Q8.8 matrix with divide by w.
// ----------------------------------------------------------------------------
`include "projective_point_transform_2d_core_defines.svh"

module projective_point_transform_2d_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  ppt_pkg::req_type            req_data,
   output logic                        rsp_valid,
   output ppt_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [ppt_pkg::RowW-1:0]    csr_data
);
   import ppt_pkg::*;

   logic [RowW-1:0] row0_ff, row1_ff, row2_ff;
   logic            cell_valid [QuoW+1];
   div_type         cell_div   [QuoW+1];
   logic            rsp_valid_ff;
   rsp_type         rsp_ff, rsp_in;
   lane_type        fx, fy;
   logic            sat_x, sat_y;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff <= Row0Reset;
         row1_ff <= Row1Reset;
         row2_ff <= Row2Reset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_ROW0: row0_ff <= csr_data;
            CSR_ROW1: row1_ff <= csr_data;
            CSR_ROW2: row2_ff <= csr_data;
            default:  ;
         endcase
      end
   end

   ppt_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .req       (req_data),
      .row0      (row0_ff),
      .row1      (row1_ff),
      .row2      (row2_ff),
      .out_valid (cell_valid[0]),
      .div       (cell_div[0])
   );

   for (genvar i = 0; i < QuoW; i++) begin : g_cell
      ppt_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[i]),
         .in_div    (cell_div[i]),
         .out_valid (cell_valid[i+1]),
         .out_div   (cell_div[i+1])
      );
   end

   // clamp the magnitude, then apply the sign; a zero w forces zero outputs
   always_comb begin
      fx    = cell_div[QuoW].lx;
      fy    = cell_div[QuoW].ly;
      sat_x = fx.ovf || (fx.neg ? (fx.quo > {1'b1, {(QuoW-1){1'b0}}})
                                : fx.quo[QuoW-1]);
      sat_y = fy.ovf || (fy.neg ? (fy.quo > {1'b1, {(QuoW-1){1'b0}}})
                                : fy.quo[QuoW-1]);
      if (sat_x) begin
         rsp_in.out_x = fx.neg ? {1'b1, {(QuoW-1){1'b0}}} : {1'b0, {(QuoW-1){1'b1}}};
      end else begin
         rsp_in.out_x = fx.neg ? -fx.quo : fx.quo;
      end
      if (sat_y) begin
         rsp_in.out_y = fy.neg ? {1'b1, {(QuoW-1){1'b0}}} : {1'b0, {(QuoW-1){1'b1}}};
      end else begin
         rsp_in.out_y = fy.neg ? -fy.quo : fy.quo;
      end
      rsp_in.w_zero    = cell_div[QuoW].w_zero;
      rsp_in.saturated = sat_x || sat_y;
      if (cell_div[QuoW].w_zero) begin
         rsp_in.out_x     = '0;
         rsp_in.out_y     = '0;
         rsp_in.saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cell_valid[QuoW];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PPT_ASSERT_NOW(a_wzero_clean, clock, reset, rsp_valid && rsp_data.w_zero,
      rsp_data.out_x == '0 && rsp_data.out_y == '0 && !rsp_data.saturated)
   `PPT_ASSERT_NEXT(a_accept_enters, clock, reset, start && !busy, ##2 cell_valid[0])
   `PPT_ASSERT_NEXT(a_row0_write, clock, reset,
      csr_valid && csr_ready && csr_index == CSR_ROW0, row0_ff == $past(csr_data))
   `PPT_ASSERT_NEXT(a_chain_out, clock, reset, cell_valid[QuoW], rsp_valid)

endmodule
